// ----- hw/rtl/delta_list_task_scheduler_macros.svh -----
// Assertion macros for the scheduler RTL.
`ifndef DELTA_LIST_TASK_SCHEDULER_MACROS_SVH
`define DELTA_LIST_TASK_SCHEDULER_MACROS_SVH

// Check a property on every rising edge outside reset.
`define DLTS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every rising edge, reset included.
`define DLTS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- hw/rtl/dlts_pkg.sv -----
// Types, codes and helpers shared by the delta-list scheduler modules.
`default_nettype none
package dlts_pkg;

  localparam int MAX_TASKS = 32;
  localparam int ID_W      = 8;
  localparam int DELTA_W   = 13;
  localparam int MS_W      = 16;
  localparam int SLOT_W    = 6;
  localparam int CNT_W     = $clog2(MAX_TASKS + 1);
  localparam int IDX_W     = $clog2(MAX_TASKS);

  // ms / 10 as multiply by reciprocal, exact over 16-bit inputs
  localparam int TICK_MUL   = 52429;
  localparam int TICK_SHIFT = 19;

  localparam logic [1:0] REQ_TICK = 2'd0;
  localparam logic [1:0] REQ_ADD  = 2'd1;
  localparam logic [1:0] REQ_DISP = 2'd2;

  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_NONE   = 2'd2;
  localparam logic [1:0] ST_REFAIL = 2'd3;

  // read address select
  localparam logic [2:0] RA_HEAD = 3'd0;
  localparam logic [2:0] RA_POS1 = 3'd1;
  localparam logic [2:0] RA_KM1  = 3'd2;
  localparam logic [2:0] RA_KM2  = 3'd3;

  // write select
  localparam logic [2:0] WA_NONE  = 3'd0;
  localparam logic [2:0] WA_TICK  = 3'd1;
  localparam logic [2:0] WA_SHIFT = 3'd2;
  localparam logic [2:0] WA_INS   = 3'd3;
  localparam logic [2:0] WA_CORR  = 3'd4;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [DELTA_W-1:0] delta;
    logic [DELTA_W-1:0] period;
  } entry_t;

  typedef struct packed {
    logic       latch;
    logic [2:0] rd_sel;
    logic [2:0] wr_sel;
    logic       walk_init;
    logic       ins_from_req;
    logic       release_head;
    logic       walk_step;
    logic       walk_fail;
    logic       shift_init;
    logic       k_dec;
    logic       tick_due;
    logic       remove;
    logic       status_we;
    logic [1:0] status_code;
    logic       out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [1:0] req;
    logic       count_zero;
    logic       full;
    logic       head_due;
    logic       rd_delta_zero;
    logic       rd_period_zero;
    logic       walk_pass;
    logic       pos1_at_n;
    logic       k_at_pos;
    logic       km1_gt_pos;
    logic       corr_pend;
    logic       out_busy;
  } dp_stat_t;

  function automatic logic [DELTA_W-1:0] ms_to_ticks(input logic [MS_W-1:0] ms);
    logic [2*MS_W-1:0] p;
    p = (2*MS_W)'(ms) * (2*MS_W)'(TICK_MUL);
    return p[TICK_SHIFT +: DELTA_W];
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/dlts_dp.sv -----
// Datapath: entry memory, list pointers, walk and shift registers, result registers.
`default_nettype none
`include "delta_list_task_scheduler_macros.svh"
module dlts_dp (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire dlts_pkg::ctrl_cmd_t           cmd,
  output dlts_pkg::dp_stat_t                 stat,
  input  wire logic [1:0]                    req_type,
  input  wire logic [dlts_pkg::ID_W-1:0]     task_id,
  input  wire logic [dlts_pkg::MS_W-1:0]     delay_ms,
  input  wire logic [dlts_pkg::MS_W-1:0]     period_ms,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [1:0]                         out_status,
  output logic                               out_run_valid,
  output logic [dlts_pkg::ID_W-1:0]          out_run_id,
  output logic [dlts_pkg::SLOT_W-1:0]        out_slot
);

  localparam int CNT_W   = dlts_pkg::CNT_W;
  localparam int IDX_W   = dlts_pkg::IDX_W;
  localparam int DELTA_W = dlts_pkg::DELTA_W;

  function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] b,
                                            input logic [CNT_W-1:0] l);
    logic [CNT_W:0] s;
    s = (CNT_W+1)'(b) + (CNT_W+1)'(l);
    if (s >= (CNT_W+1)'(dlts_pkg::MAX_TASKS)) s = s - (CNT_W+1)'(dlts_pkg::MAX_TASKS);
    return s[IDX_W-1:0];
  endfunction

  dlts_pkg::entry_t mem [dlts_pkg::MAX_TASKS];
  dlts_pkg::entry_t rd_data_r;
  dlts_pkg::entry_t corr_r;
  dlts_pkg::entry_t wdata;

  logic [1:0]                 req_r;
  logic [dlts_pkg::ID_W-1:0]  id_r, ins_id_r;
  logic [DELTA_W-1:0]         dly_r, per_r, ins_dly_r, ins_per_r;
  logic [DELTA_W-1:0]         sum_r, new_delta;
  logic [CNT_W-1:0]           pos_r, k_r, count_r;
  logic [IDX_W-1:0]           base_r;
  logic                       head_due_r, corr_pend_r;
  logic [1:0]                 status_r;
  logic                       run_valid_r;
  logic [dlts_pkg::ID_W-1:0]  run_id_r;
  logic [dlts_pkg::SLOT_W-1:0] slot_r;
  logic                       out_valid_r;
  logic [1:0]                 out_status_r;
  logic                       out_run_valid_r;
  logic [dlts_pkg::ID_W-1:0]  out_run_id_r;
  logic [dlts_pkg::SLOT_W-1:0] out_slot_r;

  logic [CNT_W-1:0] rd_log, wr_log;
  logic             we;
  logic [DELTA_W:0] walk_sum;

  assign new_delta = ins_dly_r - sum_r;
  assign walk_sum  = (DELTA_W+1)'(sum_r) + (DELTA_W+1)'(rd_data_r.delta);

  always_comb begin
    case (cmd.rd_sel)
      dlts_pkg::RA_POS1: rd_log = pos_r + 1'b1;
      dlts_pkg::RA_KM1:  rd_log = k_r - 1'b1;
      dlts_pkg::RA_KM2:  rd_log = k_r - CNT_W'(2);
      default:           rd_log = '0;
    endcase
  end

  always_comb begin
    we     = 1'b1;
    wr_log = '0;
    wdata  = rd_data_r;
    case (cmd.wr_sel)
      dlts_pkg::WA_TICK: begin
        wdata.delta = rd_data_r.delta - 1'b1;
      end
      dlts_pkg::WA_SHIFT: begin
        wr_log = k_r;
      end
      dlts_pkg::WA_INS: begin
        wr_log       = pos_r;
        wdata.id     = ins_id_r;
        wdata.delta  = new_delta;
        wdata.period = ins_per_r;
      end
      dlts_pkg::WA_CORR: begin
        wr_log      = pos_r + 1'b1;
        wdata       = corr_r;
        wdata.delta = corr_r.delta - new_delta;
      end
      default: we = 1'b0;
    endcase
  end

  // entry memory: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) mem[phys(base_r, wr_log)] <= wdata;
    rd_data_r <= mem[phys(base_r, rd_log)];
  end

  // list control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      base_r      <= '0;
      head_due_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.tick_due) head_due_r <= 1'b1;
      if (cmd.release_head) head_due_r <= 1'b0;
      if (cmd.wr_sel == dlts_pkg::WA_INS) count_r <= count_r + 1'b1;
      if (cmd.remove) begin
        count_r    <= count_r - 1'b1;
        head_due_r <= 1'b0;
        base_r     <= (base_r == IDX_W'(dlts_pkg::MAX_TASKS - 1)) ? '0 : base_r + 1'b1;
      end
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // request, walk and result payload
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_r       <= req_type;
      id_r        <= task_id;
      dly_r       <= dlts_pkg::ms_to_ticks(delay_ms);
      per_r       <= dlts_pkg::ms_to_ticks(period_ms);
      status_r    <= dlts_pkg::ST_DONE;
      run_valid_r <= 1'b0;
      run_id_r    <= '0;
      slot_r      <= '0;
    end
    if (cmd.ins_from_req) begin
      ins_id_r  <= id_r;
      ins_dly_r <= dly_r;
      ins_per_r <= per_r;
    end
    if (cmd.release_head) begin
      run_valid_r <= 1'b1;
      run_id_r    <= rd_data_r.id;
      ins_id_r    <= rd_data_r.id;
      ins_dly_r   <= rd_data_r.period;
      ins_per_r   <= rd_data_r.period;
    end
    if (cmd.walk_init) begin
      sum_r       <= '0;
      pos_r       <= '0;
      corr_pend_r <= 1'b0;
    end
    if (cmd.walk_step) begin
      sum_r <= walk_sum[DELTA_W-1:0];
      pos_r <= pos_r + 1'b1;
    end
    if (cmd.walk_fail) begin
      corr_r      <= rd_data_r;
      corr_pend_r <= 1'b1;
    end
    if (cmd.shift_init) k_r <= count_r;
    else if (cmd.k_dec) k_r <= k_r - 1'b1;
    if (cmd.status_we) status_r <= cmd.status_code;
    if (cmd.wr_sel == dlts_pkg::WA_INS && req_r == dlts_pkg::REQ_ADD)
      slot_r <= dlts_pkg::SLOT_W'(pos_r);
    if (cmd.out_load) begin
      out_status_r    <= status_r;
      out_run_valid_r <= run_valid_r;
      out_run_id_r    <= run_id_r;
      out_slot_r      <= slot_r;
    end
  end

  always_comb begin
    stat.req            = req_r;
    stat.count_zero     = (count_r == '0);
    stat.full           = (count_r == CNT_W'(dlts_pkg::MAX_TASKS));
    stat.head_due       = head_due_r;
    stat.rd_delta_zero  = (rd_data_r.delta == '0);
    stat.rd_period_zero = (rd_data_r.period == '0);
    stat.walk_pass      = (walk_sum <= (DELTA_W+1)'(ins_dly_r));
    stat.pos1_at_n      = ((CNT_W+1)'(pos_r) + 1'b1) == (CNT_W+1)'(count_r);
    stat.k_at_pos       = (k_r == pos_r);
    stat.km1_gt_pos     = (CNT_W+1)'(k_r) > ((CNT_W+1)'(pos_r) + 1'b1);
    stat.corr_pend      = corr_pend_r;
    stat.out_busy       = out_valid_r && !out_ready;
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_run_valid = out_run_valid_r;
  assign out_run_id    = out_run_id_r;
  assign out_slot      = out_slot_r;

  `DLTS_ASSERT(a_count_bound, clk, rst_n, count_r <= CNT_W'(dlts_pkg::MAX_TASKS), "entry count above capacity")
  `DLTS_ASSERT(a_ins_grows, clk, rst_n, (cmd.wr_sel == dlts_pkg::WA_INS) |=> (count_r == CNT_W'($past(count_r) + 1'b1)), "insert did not grow the list")
  `DLTS_ASSERT(a_remove, clk, rst_n, cmd.remove |=> (!head_due_r && count_r == CNT_W'($past(count_r) - 1'b1)), "head removal left list inconsistent")

endmodule
`default_nettype wire

// ----- hw/rtl/dlts_ctrl.sv -----
// Controller: sequences tick, add and dispatch requests over the datapath.
`default_nettype none
module dlts_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire dlts_pkg::dp_stat_t stat,
  output dlts_pkg::ctrl_cmd_t     cmd
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DECODE   = 4'd1;
  localparam logic [3:0] S_TICK_WB  = 4'd2;
  localparam logic [3:0] S_DISP_RD  = 4'd3;
  localparam logic [3:0] S_WALK_CHK = 4'd4;
  localparam logic [3:0] S_SHIFT    = 4'd5;
  localparam logic [3:0] S_SHIFT_WR = 4'd6;
  localparam logic [3:0] S_INS_WR   = 4'd7;
  localparam logic [3:0] S_CORR_WR  = 4'd8;
  localparam logic [3:0] S_REMOVE   = 4'd9;
  localparam logic [3:0] S_FIN      = 4'd10;

  logic [3:0] state_r, state_nxt;
  logic [3:0] after_ins;

  assign in_ready  = (state_r == S_IDLE);
  assign after_ins = (stat.req == dlts_pkg::REQ_DISP) ? S_REMOVE : S_FIN;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    cmd        = '0;
    cmd.rd_sel = dlts_pkg::RA_HEAD;
    cmd.wr_sel = dlts_pkg::WA_NONE;
    state_nxt  = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat.req)
          dlts_pkg::REQ_TICK: begin
            state_nxt = stat.count_zero ? S_FIN : S_TICK_WB;
          end
          dlts_pkg::REQ_ADD: begin
            if (stat.full) begin
              cmd.status_we   = 1'b1;
              cmd.status_code = dlts_pkg::ST_FULL;
              state_nxt       = S_FIN;
            end else begin
              cmd.ins_from_req = 1'b1;
              cmd.walk_init    = 1'b1;
              cmd.shift_init   = 1'b1;
              state_nxt        = stat.count_zero ? S_SHIFT : S_WALK_CHK;
            end
          end
          dlts_pkg::REQ_DISP: begin
            if (!stat.count_zero && stat.head_due) begin
              state_nxt = S_DISP_RD;
            end else begin
              cmd.status_we   = 1'b1;
              cmd.status_code = dlts_pkg::ST_NONE;
              state_nxt       = S_FIN;
            end
          end
          default: state_nxt = S_FIN;
        endcase
      end
      S_TICK_WB: begin
        if (stat.rd_delta_zero) cmd.tick_due = 1'b1;
        else                    cmd.wr_sel   = dlts_pkg::WA_TICK;
        state_nxt = S_FIN;
      end
      S_DISP_RD: begin
        cmd.release_head = 1'b1;
        if (stat.rd_period_zero) begin
          state_nxt = S_REMOVE;
        end else if (stat.full) begin
          cmd.status_we   = 1'b1;
          cmd.status_code = dlts_pkg::ST_REFAIL;
          state_nxt       = S_REMOVE;
        end else begin
          cmd.walk_init = 1'b1;
          state_nxt     = S_WALK_CHK;
        end
      end
      S_WALK_CHK: begin
        if (stat.walk_pass) begin
          cmd.walk_step = 1'b1;
          if (stat.pos1_at_n) begin
            cmd.shift_init = 1'b1;
            state_nxt      = S_SHIFT;
          end else begin
            cmd.rd_sel = dlts_pkg::RA_POS1;
          end
        end else begin
          cmd.walk_fail  = 1'b1;
          cmd.shift_init = 1'b1;
          state_nxt      = S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (stat.k_at_pos) begin
          state_nxt = S_INS_WR;
        end else begin
          cmd.rd_sel = dlts_pkg::RA_KM1;
          state_nxt  = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        cmd.wr_sel = dlts_pkg::WA_SHIFT;
        cmd.k_dec  = 1'b1;
        if (stat.km1_gt_pos) cmd.rd_sel = dlts_pkg::RA_KM2;
        else                 state_nxt  = S_INS_WR;
      end
      S_INS_WR: begin
        cmd.wr_sel = dlts_pkg::WA_INS;
        state_nxt  = stat.corr_pend ? S_CORR_WR : after_ins;
      end
      S_CORR_WR: begin
        cmd.wr_sel = dlts_pkg::WA_CORR;
        state_nxt  = after_ins;
      end
      S_REMOVE: begin
        cmd.remove = 1'b1;
        state_nxt  = S_FIN;
      end
      S_FIN: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ----- hw/rtl/delta_list_task_scheduler.sv -----
// Top level: delta-list timer queue with streaming request and result channels.
// An add or periodic re-add walks the queued entries to find its slot and shifts the later
// entries to make room.
// Requests are taken one at a time; the next is accepted once the result is loaded.
// Reset (synchronous, active low) empties the list; entries need no clearing.
`default_nettype none
module delta_list_task_scheduler (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // request channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // task_id[7:0], delay_ms[23:8], period_ms[39:24]
  input  wire logic [1:0]  in_tuser,   // req_type[1:0]
  // result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // run_id[7:0], slot[13:8], zero fill[15:14]
  output logic [2:0]       out_tuser   // status[1:0], run_valid[2]
);

  dlts_pkg::ctrl_cmd_t cmd;
  dlts_pkg::dp_stat_t  stat;

  logic [1:0]                    res_status;
  logic                          res_run_valid;
  logic [dlts_pkg::ID_W-1:0]     res_run_id;
  logic [dlts_pkg::SLOT_W-1:0]   res_slot;

  // Sequence each request: tick the head, or walk the list, shift, insert, correct, remove.
  dlts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Hold the entries in a circular memory; head removal advances the base.
  dlts_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .req_type      (in_tuser),
    .task_id       (in_tdata[7:0]),
    .delay_ms      (in_tdata[23:8]),
    .period_ms     (in_tdata[39:24]),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .out_status    (res_status),
    .out_run_valid (res_run_valid),
    .out_run_id    (res_run_id),
    .out_slot      (res_slot)
  );

  // Pack the result request; the output register lets a new request in while it waits.
  assign out_tdata = {2'b00, res_slot, res_run_id};
  assign out_tuser = {res_run_valid, res_status};

endmodule
`default_nettype wire
